/* design/atoi_pkg.sv */
`timescale 1ns / 1ps

package atoi_pkg;

    localparam int MAX_CHARS = 4096;
    localparam int STOP_W    = 12;
    localparam int STOP_CAP  = (MAX_CHARS - 1 < 4095) ? MAX_CHARS - 1 : 4095;

    localparam int BASE_W    = 6;
    localparam int CHAR_W    = 8;
    localparam int VALUE_W   = 64;
    localparam int OUT_W     = 80;

    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_LOW_X = 8'h78;

    localparam logic [BASE_W-1:0] NO_DIGIT   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_BAD   = 6'd1;
    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;

    typedef struct packed {
        logic [BASE_W-1:0] digit;
        logic              is_space;
        logic              is_minus;
        logic              is_low_x;
        logic              last;
    } char_class_t;

    function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = 8'd36;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
        end else if (c inside {[8'h61:8'h7a]}) begin
            d = c - 8'h61 + 8'd10;
        end else if (c inside {[8'h41:8'h5a]}) begin
            d = c - 8'h41 + 8'd10;
        end
        return d[BASE_W-1:0];
    endfunction

endpackage

/* design/atoi_front.sv */
`timescale 1ns / 1ps

module atoi_front
    import atoi_pkg::*;
(
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,
    input  logic              s_tlast,
    output logic              push_valid,
    input  logic              push_ready,
    output char_class_t       push_data
);

    always_comb begin
        push_data.digit    = digit_of(s_tdata);
        push_data.is_space = (s_tdata == CHAR_SPACE);
        push_data.is_minus = (s_tdata == CHAR_MINUS);
        push_data.is_low_x = (s_tdata == CHAR_LOW_X);
        push_data.last     = s_tlast;
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

/* design/atoi_queue.sv */
`timescale 1ns / 1ps

module atoi_queue
    import atoi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    output logic        push_ready,
    input  char_class_t push_data,
    output logic        pop_valid,
    input  logic        pop_ready,
    output char_class_t pop_data
);

    char_class_t             slots_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]      wr_ptr_reg;
    logic [Q_PTR_W-1:0]      rd_ptr_reg;
    logic [Q_CNT_W-1:0]      count_reg;
    logic                    push_fire;
    logic                    pop_fire;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_fire) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push_fire && pop_fire) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

/* design/atoi_back.sv */
`timescale 1ns / 1ps

module atoi_back
    import atoi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [BASE_W-1:0] cfg_wr_data,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  char_class_t       pop_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata
);

    typedef enum logic [5:0] {
        PH_SPACE  = 6'b000001,
        PH_SIGN   = 6'b000010,
        PH_AUTO0  = 6'b000100,
        PH_HEX0   = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    logic [BASE_W-1:0]  number_base_reg;
    phase_t             phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [BASE_W-1:0]  base_reg, base_next;
    logic [STOP_W-1:0]  pos_reg, pos_next;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_acc_reg;
    logic               out_neg_reg;
    logic [STOP_W-1:0]  out_stop_reg;
    logic               out_bad_reg;

    phase_t             ph;
    logic               neg;
    logic [VALUE_W-1:0] acc;
    logic [BASE_W-1:0]  base;
    logic [STOP_W-1:0]  pos;
    logic               used;
    logic               emit;
    logic [STOP_W-1:0]  e_stop;
    logic               e_bad;
    logic               pop_fire;
    logic [VALUE_W-1:0] out_value;

    assign pop_ready = !out_valid_reg || m_tready;
    assign pop_fire  = pop_valid && pop_ready;

    always_comb begin
        ph     = phase_reg;
        neg    = neg_reg;
        acc    = acc_reg;
        base   = base_reg;
        pos    = pos_reg;
        used   = 1'b0;
        emit   = 1'b0;
        e_stop = '0;
        e_bad  = 1'b0;

        // base is latched at the first character of a string
        if (phase_reg == PH_SPACE && pos_reg == '0) begin
            base = number_base_reg;
            if (base == BASE_BAD || base > BASE_MAX) begin
                emit  = 1'b1;
                e_bad = 1'b1;
                ph    = PH_DONE;
            end
        end

        if (ph != PH_DONE) begin
            if (ph == PH_SPACE) begin
                if (pop_data.is_space) begin
                    used = 1'b1;
                end else if (pop_data.is_minus) begin
                    neg  = 1'b1;
                    ph   = PH_SIGN;
                    used = 1'b1;
                end else begin
                    ph = PH_SIGN;
                end
            end
            if (!used && ph == PH_SIGN) begin
                if (base == BASE_AUTO) begin
                    if (pop_data.digit == '0) begin
                        ph   = PH_AUTO0;
                        used = 1'b1;
                    end else begin
                        base = BASE_DEC;
                        ph   = PH_DIGITS;
                    end
                end else if (base == BASE_HEX && pop_data.digit == '0) begin
                    ph   = PH_HEX0;
                    used = 1'b1;
                end else begin
                    ph = PH_DIGITS;
                end
            end
            if (!used && ph == PH_AUTO0) begin
                if (pop_data.is_low_x) begin
                    base = BASE_HEX;
                    used = 1'b1;
                end else begin
                    base = BASE_OCT;
                end
                ph = PH_DIGITS;
            end
            if (!used && ph == PH_HEX0) begin
                if (pop_data.is_low_x) begin
                    used = 1'b1;
                end
                ph = PH_DIGITS;
            end
            if (!used && ph == PH_DIGITS) begin
                if (pop_data.digit < base) begin
                    acc  = VALUE_W'(acc_reg * VALUE_W'(base)) + VALUE_W'(pop_data.digit);
                    used = 1'b1;
                end else begin
                    emit   = 1'b1;
                    e_stop = pos_reg;
                    ph     = PH_DONE;
                end
            end
            if (used && pos_reg < STOP_W'(STOP_CAP)) begin
                pos = pos_reg + 1'b1;
            end
        end

        if (pop_data.last && ph != PH_DONE) begin
            emit   = 1'b1;
            e_stop = pos;
            ph     = PH_DONE;
        end

        if (pop_data.last) begin
            phase_next = PH_SPACE;
            neg_next   = 1'b0;
            acc_next   = '0;
            base_next  = '0;
            pos_next   = '0;
        end else begin
            phase_next = ph;
            neg_next   = neg;
            acc_next   = acc;
            base_next  = base;
            pos_next   = pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_base_reg <= BASE_DEC;
            phase_reg       <= PH_SPACE;
            neg_reg         <= 1'b0;
            acc_reg         <= '0;
            base_reg        <= '0;
            pos_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                number_base_reg <= cfg_wr_data;
            end
            if (pop_fire) begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                base_reg  <= base_next;
                pos_reg   <= pos_next;
            end
            if (pop_fire && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_fire && emit) begin
            out_acc_reg  <= acc;
            out_neg_reg  <= neg;
            out_stop_reg <= e_stop;
            out_bad_reg  <= e_bad;
        end
    end

    assign out_value = out_neg_reg ? ('0 - out_acc_reg) : out_acc_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OUT_W - VALUE_W - STOP_W - 1){1'b0}}, out_bad_reg, out_stop_reg,
                        out_value};

`ifndef ASSERT_OFF
    a_space_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SPACE |-> (acc_reg == '0 && !neg_reg))
        else $error("accumulator or sign not clear in leading space phase");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_fire && pop_data.last |=> (phase_reg == PH_SPACE && pos_reg == '0))
        else $error("string state not cleared after last character");

    a_bad_base_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_bad_reg |-> (out_stop_reg == '0 && out_acc_reg == '0))
        else $error("bad base result carries nonzero payload");
`endif

endmodule

/* design/ascii_to_integer_parser.sv */
`timescale 1ns / 1ps

// strtol-style parser: characters arrive one per transfer on s_, s_tlast marks the
// end of a string, and each string yields at most one result transfer on m_ holding
// the signed 64-bit value (wrapped), the saturating stop index and a bad-base flag.
// The parser sustains one character per cycle while no result waits on m_tready;
// the limit is the accumulator multiply-add by the base in the back end, which
// retires one character a cycle. Characters are registered in the 4-entry queue's
// slots before the output register. cfg_wr_data (0 auto, 2..36 radix) takes effect
// at the first character of the next string and should be written only while idle.

module ascii_to_integer_parser
    import atoi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [BASE_W-1:0] cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,   // ch
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // value[63:0], stop_index[75:64], bad_base[76]
);

    logic        push_valid;
    logic        push_ready;
    char_class_t push_data;
    logic        pop_valid;
    logic        pop_ready;
    char_class_t pop_data;

    atoi_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    atoi_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    atoi_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

/* verif/tb_ascii_to_integer_parser.sv */
`timescale 1ns / 1ps

module tb_ascii_to_integer_parser;
    import atoi_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int ITEMS_PER_BASE = 72;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOW_Z = 8'h7a;
    localparam logic [CHAR_W-1:0] CHAR_UP_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_X = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z = 8'h5a;
    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TOP = 8'hff;

    typedef enum logic [2:0] {
        SKIP_SPACE,
        SAW_SIGN,
        SAW_AUTO_ZERO,
        SAW_HEX_ZERO,
        TAKE_DIGITS,
        STRING_DONE
    } parse_phase_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_xfer_t;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [STOP_W-1:0]  stop;
        logic               bad;
    } parse_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [BASE_W-1:0] cfg_wr_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [CHAR_W-1:0] s_tdata = '0;   // ch
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;        // value[63:0], stop_index[75:64], bad_base[76]

    char_xfer_t    text_q[$];
    parse_result_t results_due[$];

    // parser state as the block should hold it
    logic [BASE_W-1:0]  base_reg = BASE_DEC;
    parse_phase_t       str_phase = SKIP_SPACE;
    logic               str_neg = 1'b0;
    logic [VALUE_W-1:0] str_acc = '0;
    logic [BASE_W-1:0]  str_base = '0;
    int                 str_pos = 0;

    int  chars_queued = 0;
    int  chars_taken = 0;
    int  errors = 0;
    int  quiet_cycles = 0;
    int  s_gap = 0;
    int  m_stall = 3;
    bit  calm = 1'b0;
    logic s_took = 1'b0;
    logic m_took = 1'b0;

    ascii_to_integer_parser uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [BASE_W-1:0] char_weight(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] w;
        w = CHAR_W'(NO_DIGIT);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            w = c - CHAR_ZERO;
        end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
            w = c - CHAR_LOW_A + 8'd10;
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            w = c - CHAR_UP_A + 8'd10;
        end
        return w[BASE_W-1:0];
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input int d);
        if (d < 10) begin
            return CHAR_ZERO + CHAR_W'(d);
        end
        return ($urandom_range(0, 1) ? CHAR_UP_A : CHAR_LOW_A) + CHAR_W'(d - 10);
    endfunction

    task automatic post_result(input int stop, input logic bad);
        parse_result_t r;
        r.value = str_neg ? (VALUE_W'(0) - str_acc) : str_acc;
        r.stop = (stop > STOP_CAP) ? STOP_W'(STOP_CAP) : STOP_W'(stop);
        r.bad = bad;
        results_due.push_back(r);
        str_phase = STRING_DONE;
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] ch, input logic last);
        int idx;
        logic took;
        logic [BASE_W-1:0] dig;
        idx = str_pos;
        took = 1'b0;
        // base is latched at the first character of a string
        if (str_phase == SKIP_SPACE && idx == 0) begin
            str_base = base_reg;
            if (str_base == BASE_BAD || str_base > BASE_MAX) begin
                post_result(0, 1'b1);
            end
        end
        if (str_phase != STRING_DONE) begin
            if (str_phase == SKIP_SPACE) begin
                if (ch == CHAR_SPACE) begin
                    took = 1'b1;
                end else if (ch == CHAR_MINUS) begin
                    str_neg = 1'b1;
                    str_phase = SAW_SIGN;
                    took = 1'b1;
                end else begin
                    str_phase = SAW_SIGN;
                end
            end
            if (!took && str_phase == SAW_SIGN) begin
                if (str_base == BASE_AUTO) begin
                    if (ch == CHAR_ZERO) begin
                        str_phase = SAW_AUTO_ZERO;
                        took = 1'b1;
                    end else begin
                        str_base = BASE_DEC;
                        str_phase = TAKE_DIGITS;
                    end
                end else if (str_base == BASE_HEX && ch == CHAR_ZERO) begin
                    str_phase = SAW_HEX_ZERO;
                    took = 1'b1;
                end else begin
                    str_phase = TAKE_DIGITS;
                end
            end
            if (!took && str_phase == SAW_AUTO_ZERO) begin
                if (ch == CHAR_LOW_X) begin
                    str_base = BASE_HEX;
                    took = 1'b1;
                end else begin
                    str_base = BASE_OCT;
                end
                str_phase = TAKE_DIGITS;
            end
            if (!took && str_phase == SAW_HEX_ZERO) begin
                if (ch == CHAR_LOW_X) begin
                    took = 1'b1;
                end
                str_phase = TAKE_DIGITS;
            end
            if (!took && str_phase == TAKE_DIGITS) begin
                dig = char_weight(ch);
                if (dig < str_base) begin
                    str_acc = str_acc * str_base + dig;
                    took = 1'b1;
                end else begin
                    post_result(idx, 1'b0);
                end
            end
            if (took && str_pos < STOP_CAP) begin
                str_pos = idx + 1;
            end
        end
        if (last) begin
            if (str_phase != STRING_DONE) begin
                post_result(str_pos, 1'b0);
            end
            str_phase = SKIP_SPACE;
            str_neg = 1'b0;
            str_acc = '0;
            str_base = '0;
            str_pos = 0;
        end
    endtask

    task automatic flag(input string what, input logic [VALUE_W-1:0] want,
                        input logic [VALUE_W-1:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endtask

    task automatic check_result(input logic [OUT_W-1:0] got);
        parse_result_t want;
        if (results_due.size() == 0) begin
            flag("unexpected result", '0, got[VALUE_W-1:0]);
        end else begin
            want = results_due.pop_front();
            if (got[VALUE_W-1:0] !== want.value) begin
                flag("value", want.value, got[VALUE_W-1:0]);
            end
            if (got[VALUE_W +: STOP_W] !== want.stop) begin
                flag("stop_index", VALUE_W'(want.stop), VALUE_W'(got[VALUE_W +: STOP_W]));
            end
            if (got[VALUE_W+STOP_W] !== want.bad) begin
                flag("bad_base", VALUE_W'(want.bad), VALUE_W'(got[VALUE_W+STOP_W]));
            end
        end
    endtask

    // input side
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (s_took) begin
                s_gap = calm ? 0 : $urandom_range(0, 15);
            end
            if (s_gap > 0) begin
                s_tvalid <= 1'b0;
                s_gap = s_gap - 1;
            end else if (text_q.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= text_q[0].ch;
                s_tlast <= text_q[0].last;
                void'(text_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (m_took) begin
            m_stall = calm ? 0 : $urandom_range(0, 15);
        end
        if (m_stall > 0) begin
            m_tready <= 1'b0;
            m_stall = m_stall - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        s_took <= aresetn && s_tvalid && s_tready;
        m_took <= aresetn && m_tvalid && m_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                chars_taken++;
                parse_char(s_tdata, s_tlast);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic push_char(input logic [CHAR_W-1:0] ch, input logic last);
        char_xfer_t x;
        x.ch = ch;
        x.last = last;
        text_q.push_back(x);
        chars_queued++;
    endtask

    task automatic push_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i], close && i == s.len() - 1);
        end
    endtask

    task automatic wait_idle();
        while (chars_taken != chars_queued || results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_base(input logic [BASE_W-1:0] b);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= b;
        base_reg = b;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_random_string(input logic [BASE_W-1:0] radix);
        logic [CHAR_W-1:0] text[$];
        int n;
        int er;
        int kind;
        kind = $urandom_range(0, 9);
        er = (radix >= 2 && radix <= BASE_MAX) ? int'(radix) : 36;
        if (kind >= 8) begin
            // noise
            n = $urandom_range(1, 8);
            repeat (n) text.push_back(CHAR_W'($urandom_range(0, 255)));
        end else if (kind == 7) begin
            case ($urandom_range(0, 3))
                0: begin
                    repeat ($urandom_range(1, 4)) text.push_back(CHAR_SPACE);
                end
                1: begin
                    repeat ($urandom_range(0, 2)) text.push_back(CHAR_SPACE);
                    text.push_back(CHAR_MINUS);
                end
                2: begin
                    text.push_back(CHAR_ZERO);
                    text.push_back(CHAR_LOW_X);
                end
                default: begin
                    text.push_back(CHAR_ZERO);
                    text.push_back(CHAR_UP_X);
                    text.push_back(digit_char($urandom_range(0, 15)));
                end
            endcase
        end else begin
            repeat ($urandom_range(0, 3)) text.push_back(CHAR_SPACE);
            if ($urandom_range(0, 1)) begin
                text.push_back(CHAR_MINUS);
            end
            if (radix == BASE_AUTO) begin
                case ($urandom_range(0, 2))
                    0: begin
                        text.push_back(CHAR_ZERO);
                        text.push_back(CHAR_LOW_X);
                        er = 16;
                    end
                    1: begin
                        text.push_back(CHAR_ZERO);
                        er = 8;
                    end
                    default: er = 10;
                endcase
            end else if (radix == BASE_HEX && $urandom_range(0, 1)) begin
                text.push_back(CHAR_ZERO);
                text.push_back(CHAR_LOW_X);
            end
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 30) : $urandom_range(0, 6);
            repeat (n) text.push_back(digit_char($urandom_range(0, er - 1)));
            if ($urandom_range(0, 1)) begin
                if (er < 36 && $urandom_range(0, 1)) begin
                    text.push_back(digit_char($urandom_range(er, 35)));
                end else begin
                    text.push_back(CHAR_W'($urandom_range(0, 255)));
                end
                repeat ($urandom_range(0, 3)) text.push_back(CHAR_W'($urandom_range(0, 255)));
            end
        end
        if (text.size() == 0) begin
            text.push_back(CHAR_ZERO);
        end
        foreach (text[i]) begin
            push_char(text[i], i == text.size() - 1);
        end
    endtask

    initial begin
        logic [BASE_W-1:0] base_plan[$];
        int done_items;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset base of ten
        push_text("-7", 1'b1);
        push_char(CHAR_NUL, 1'b1);
        push_text(" -", 1'b1);
        push_char(CHAR_TOP, 1'b1);
        // base write in the middle of a string applies to the next one
        push_text("12", 1'b0);
        set_base(BASE_HEX);
        push_text("a", 1'b1);

        set_base(BASE_AUTO);
        push_text("0x", 1'b1);
        push_text("0X", 1'b1);
        push_text("0", 1'b1);

        set_base(BASE_MAX);
        push_text("-1y2p0ij32e8e8", 1'b1);

        set_base(BASE_BAD);
        push_text("5", 1'b1);

        base_plan = '{BASE_DEC, BASE_AUTO, BASE_HEX, 6'd2, BASE_MAX, BASE_OCT, BASE_BAD,
                      6'd37, 6'd63, BASE_W'($urandom_range(2, 36)), BASE_AUTO,
                      BASE_W'($urandom_range(3, 35))};
        foreach (base_plan[p]) begin
            set_base(base_plan[p]);
            done_items = chars_queued;
            while (chars_queued - done_items < ITEMS_PER_BASE) begin
                calm = ($urandom_range(0, 3) == 0);
                queue_random_string(base_plan[p]);
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* ascii_to_integer_parser.f */
design/atoi_pkg.sv
design/atoi_front.sv
design/atoi_queue.sv
design/atoi_back.sv
design/ascii_to_integer_parser.sv
verif/tb_ascii_to_integer_parser.sv
